// File: rtl/cdfa_pkg.sv
package cdfa_pkg;

	localparam int MAX_RES = 64;
	localparam int QDEPTH = 4;
	localparam int CLASSES = 256;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_CHAR = 2'd1;
	localparam logic [1:0] FUNC_EOT = 2'd2;

	localparam logic [2:0] TBL_CLASS = 3'd0;
	localparam logic [2:0] TBL_META = 3'd1;
	localparam logic [2:0] TBL_ACCEPT = 3'd2;
	localparam logic [2:0] TBL_BASE = 3'd3;
	localparam logic [2:0] TBL_DEFAULT = 3'd4;
	localparam logic [2:0] TBL_CHECK = 3'd5;
	localparam logic [2:0] TBL_NEXT = 3'd6;

	localparam logic [1:0] CFG_START_COND = 2'd0;
	localparam logic [1:0] CFG_META_THR = 2'd1;
	localparam logic [1:0] CFG_JAM_BASE = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NOACC = 2'd1;
	localparam logic [1:0] STAT_OVF = 2'd2;

	localparam logic [7:0] CHAR_NL = 8'h0A;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_CHAR,
		OP_EOT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] tbl;
		logic [11:0] idx;
		logic [11:0] val;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic [4:0] start_condition;
		logic [10:0] meta_threshold;
		logic [11:0] jam_base;
	} cfg_t;

	typedef struct packed {
		logic [9:0] action;
		logic [31:0] token_start;
		logic [8:0] token_length;
		logic [1:0] status;
		logic last;
	} res_t;

	function automatic logic [31:0] reduce_mod(input logic [31:0] v, input logic [31:0] m);
		logic [31:0] r;
		r = v;
		for (int k = 7; k >= 0; k--) begin
			if (r >= (m << k))
				r = r - (m << k);
		end
		return r;
	endfunction

endpackage

// File: rtl/cdfa_front.sv
module cdfa_front #(
	parameter int STATES = 1024,
	parameter int SLOTS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic [2:0] table_id,
	input logic [11:0] table_index,
	input logic [11:0] table_value,
	input logic [7:0] text_char,
	output logic q_valid,
	output cdfa_pkg::item_t q_item,
	input logic q_pop
);

	localparam int QW = $clog2(cdfa_pkg::QDEPTH);
	localparam int CW = $clog2(cdfa_pkg::QDEPTH + 1);

	cdfa_pkg::item_t fifo_q [cdfa_pkg::QDEPTH];
	logic [QW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic load_ok, keep;
	logic push;
	cdfa_pkg::item_t item_c;

	always_comb begin
		unique case (table_id)
			cdfa_pkg::TBL_CLASS, cdfa_pkg::TBL_META:
				load_ok = 32'(table_index) < 32'(cdfa_pkg::CLASSES);
			cdfa_pkg::TBL_ACCEPT, cdfa_pkg::TBL_BASE, cdfa_pkg::TBL_DEFAULT:
				load_ok = 32'(table_index) < 32'(STATES);
			cdfa_pkg::TBL_CHECK, cdfa_pkg::TBL_NEXT:
				load_ok = 32'(table_index) < 32'(SLOTS);
			default:
				load_ok = 1'b0;
		endcase
	end

	always_comb begin
		item_c.tbl = table_id;
		item_c.idx = table_index;
		item_c.val = table_value;
		item_c.ch = text_char;
		unique case (func)
			cdfa_pkg::FUNC_LOAD: begin
				item_c.op = cdfa_pkg::OP_LOAD;
				keep = load_ok;
			end
			cdfa_pkg::FUNC_CHAR: begin
				item_c.op = cdfa_pkg::OP_CHAR;
				keep = 1'b1;
			end
			cdfa_pkg::FUNC_EOT: begin
				item_c.op = cdfa_pkg::OP_EOT;
				keep = 1'b1;
			end
			default: begin
				item_c.op = cdfa_pkg::OP_LOAD;
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready = count_q != CW'(cdfa_pkg::QDEPTH);
	assign push = in_valid && in_ready && keep;
	assign q_valid = count_q != '0;
	assign q_item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QW'(1);
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + QW'(1);
			if (push && !q_pop)
				count_q <= count_q + CW'(1);
			else if (!push && q_pop)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: rtl/cdfa_back.sv
module cdfa_back #(
	parameter int STATES = 1024,
	parameter int SLOTS = 4096,
	parameter int LOOKAHEAD = 256
) (
	input logic clk,
	input logic arst_n,
	input cdfa_pkg::cfg_t cfg,
	input logic q_valid,
	input cdfa_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output cdfa_pkg::res_t res
);

	localparam int SW = $clog2(STATES);
	localparam int SLW = $clog2(SLOTS);
	localparam int AW = $clog2(LOOKAHEAD);
	localparam int PW = $clog2(LOOKAHEAD + 2);
	localparam int TW = $clog2(STATES + 1);
	localparam int RW = $clog2(cdfa_pkg::MAX_RES + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_RDC, ST_ACC, ST_W1, ST_W2, ST_META, ST_MW,
		ST_NX, ST_JAM, ST_F1, ST_F2, ST_F3, ST_F4, ST_END
	} state_t;

	state_t state_q;

	logic [7:0] class_mem [cdfa_pkg::CLASSES];
	logic [7:0] meta_mem [cdfa_pkg::CLASSES];
	logic [9:0] accept_mem [STATES];
	logic [11:0] base_mem [STATES];
	logic [9:0] default_mem [STATES];
	logic [9:0] check_mem [SLOTS];
	logic [9:0] next_mem [SLOTS];
	logic [7:0] buf_mem [LOOKAHEAD];

	logic [7:0] class_rd_q, meta_rd_q, buf_rd_q;
	logic [9:0] accept_rd_q, default_rd_q, check_rd_q, next_rd_q;
	logic [11:0] base_rd_q;

	logic class_re, meta_re, accept_re, base_re, default_re, check_re, next_re, buf_re;
	logic [7:0] class_ra, meta_ra;
	logic [SW-1:0] accept_ra, base_ra, default_ra;
	logic [SLW-1:0] check_ra, next_ra;
	logic [AW-1:0] buf_ra, buf_wa;
	logic buf_we;
	logic ld_we;

	logic [SW-1:0] dfa_q, la_state_q, w_q;
	logic [PW-1:0] la_off_q, scan_pos_q, buf_cnt_q, len_q;
	logic [AW-1:0] head_q;
	logic [TW-1:0] steps_q;
	logic [RW-1:0] res_cnt_q;
	logic [SLW-1:0] slot_q;
	logic [7:0] off_q;
	logic [9:0] act_q;
	logic [31:0] text_off_q;
	logic lsf_q, at_end_q, sent_q;
	logic pend_v_q, out_v_q;
	cdfa_pkg::res_t pend_q, out_q;

	logic [SLW-1:0] slot_c;
	logic [SW-1:0] w_new, d_new;
	logic hit, meta_hit, out_free, pend_ok, noacc;
	logic [PW-1:0] cons, cons_raw, f1_len;
	logic [PW:0] scan_sum, cnt_sum, last_sum;

	function automatic logic [AW-1:0] wrap(input logic [PW:0] v);
		if (32'(v) >= 32'(LOOKAHEAD))
			return AW'(32'(v) - 32'(LOOKAHEAD));
		return AW'(v);
	endfunction

	function automatic logic [SW-1:0] start_state(input logic [4:0] sc, input logic ls);
		logic [31:0] v;
		v = (32'(sc) << 1) + 32'(1) + 32'(ls);
		return SW'(cdfa_pkg::reduce_mod(v, 32'(STATES)));
	endfunction

	assign slot_c = SLW'(cdfa_pkg::reduce_mod(32'(base_rd_q) + 32'(off_q), 32'(SLOTS)));
	assign w_new = SW'(cdfa_pkg::reduce_mod(32'(default_rd_q), 32'(STATES)));
	assign d_new = SW'(cdfa_pkg::reduce_mod(32'(next_rd_q), 32'(STATES)));
	assign hit = (32'(check_rd_q) == 32'(w_q)) || (32'(steps_q) == 32'(STATES));
	assign meta_hit = 32'(w_new) >= 32'(cfg.meta_threshold);
	assign out_free = !out_v_q || out_ready;
	assign pend_ok = !pend_v_q || out_free;

	assign noacc = (act_q == '0) || (len_q == '0);
	assign cons_raw = noacc ? PW'(1) : len_q;
	assign cons = (cons_raw > buf_cnt_q) ? buf_cnt_q : cons_raw;
	assign f1_len = (sent_q && scan_pos_q > buf_cnt_q) ? buf_cnt_q : scan_pos_q;

	assign scan_sum = {1'b0, PW'(head_q)} + {1'b0, scan_pos_q};
	assign cnt_sum = {1'b0, PW'(head_q)} + {1'b0, buf_cnt_q};
	assign last_sum = {1'b0, PW'(head_q)} + {1'b0, cons} - (PW + 1)'(1);

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_v_q;
	assign res = out_q;

	always_comb begin
		class_re = 1'b0; meta_re = 1'b0; accept_re = 1'b0; base_re = 1'b0;
		default_re = 1'b0; check_re = 1'b0; next_re = 1'b0; buf_re = 1'b0;
		class_ra = sent_q ? 8'd0 : buf_rd_q;
		meta_ra = off_q;
		accept_ra = dfa_q;
		base_ra = dfa_q;
		default_ra = w_q;
		check_ra = slot_c;
		next_ra = slot_q;
		buf_ra = wrap(scan_sum);
		buf_wa = wrap(cnt_sum);
		buf_we = 1'b0;
		ld_we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ld_we = q_valid && q_item.op == cdfa_pkg::OP_LOAD;
				buf_we = q_valid && q_item.op == cdfa_pkg::OP_CHAR;
			end
			ST_SCAN: buf_re = 1'b1;
			ST_RDC: begin
				class_re = 1'b1;
				accept_re = 1'b1;
			end
			ST_ACC: base_re = 1'b1;
			ST_W1: begin
				check_re = 1'b1;
				default_re = 1'b1;
			end
			ST_W2: begin
				next_re = hit;
				base_re = !hit && !meta_hit;
				base_ra = w_new;
			end
			ST_META: begin
				meta_re = 1'b1;
				base_re = 1'b1;
				base_ra = w_q;
			end
			ST_NX: begin
				base_re = 1'b1;
				base_ra = d_new;
			end
			ST_JAM: accept_re = 1'b1;
			ST_F1: begin
				accept_re = 1'b1;
				accept_ra = la_state_q;
			end
			ST_F3: begin
				buf_re = 1'b1;
				buf_ra = wrap(last_sum);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_we && q_item.tbl == cdfa_pkg::TBL_CLASS)
			class_mem[q_item.idx[7:0]] <= q_item.val[7:0];
		if (class_re)
			class_rd_q <= class_mem[class_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we && q_item.tbl == cdfa_pkg::TBL_META)
			meta_mem[q_item.idx[7:0]] <= q_item.val[7:0];
		if (meta_re)
			meta_rd_q <= meta_mem[meta_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we && q_item.tbl == cdfa_pkg::TBL_ACCEPT)
			accept_mem[SW'(q_item.idx)] <= q_item.val[9:0];
		if (accept_re)
			accept_rd_q <= accept_mem[accept_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we && q_item.tbl == cdfa_pkg::TBL_BASE)
			base_mem[SW'(q_item.idx)] <= q_item.val;
		if (base_re)
			base_rd_q <= base_mem[base_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we && q_item.tbl == cdfa_pkg::TBL_DEFAULT)
			default_mem[SW'(q_item.idx)] <= q_item.val[9:0];
		if (default_re)
			default_rd_q <= default_mem[default_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we && q_item.tbl == cdfa_pkg::TBL_CHECK)
			check_mem[SLW'(q_item.idx)] <= q_item.val[9:0];
		if (check_re)
			check_rd_q <= check_mem[check_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we && q_item.tbl == cdfa_pkg::TBL_NEXT)
			next_mem[SLW'(q_item.idx)] <= q_item.val[9:0];
		if (next_re)
			next_rd_q <= next_mem[next_ra];
	end

	always_ff @(posedge clk) begin
		if (buf_we)
			buf_mem[buf_wa] <= q_item.ch;
		if (buf_re)
			buf_rd_q <= buf_mem[buf_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dfa_q <= SW'(2);
			la_state_q <= '0;
			la_off_q <= '0;
			lsf_q <= 1'b1;
			text_off_q <= '0;
			buf_cnt_q <= '0;
			scan_pos_q <= '0;
			head_q <= '0;
			res_cnt_q <= '0;
			at_end_q <= 1'b0;
			sent_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
			w_q <= '0;
			steps_q <= '0;
			slot_q <= '0;
			off_q <= '0;
			act_q <= '0;
			len_q <= '0;
			pend_q <= '0;
			out_q <= '0;
		end else begin
			if (out_v_q && out_ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						res_cnt_q <= '0;
						unique case (q_item.op)
							cdfa_pkg::OP_CHAR: begin
								at_end_q <= 1'b0;
								state_q <= ST_SCAN;
								if (32'(buf_cnt_q) >= 32'(LOOKAHEAD)) begin
									pend_q <= '{action: '0, token_start: text_off_q,
										token_length: 9'(buf_cnt_q),
										status: cdfa_pkg::STAT_OVF, last: 1'b0};
									pend_v_q <= 1'b1;
									res_cnt_q <= RW'(1);
									text_off_q <= text_off_q + 32'(buf_cnt_q);
									buf_cnt_q <= PW'(1);
									scan_pos_q <= '0;
								end else begin
									buf_cnt_q <= buf_cnt_q + PW'(1);
								end
							end
							cdfa_pkg::OP_EOT: begin
								at_end_q <= 1'b1;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (32'(res_cnt_q) == 32'(cdfa_pkg::MAX_RES)) begin
						state_q <= ST_END;
					end else if (scan_pos_q < buf_cnt_q
						|| (at_end_q && buf_cnt_q != '0)) begin
						sent_q <= !(scan_pos_q < buf_cnt_q);
						state_q <= ST_RDC;
						if (scan_pos_q == '0) begin
							dfa_q <= start_state(cfg.start_condition, lsf_q);
							la_state_q <= '0;
							la_off_q <= '0;
						end
					end else begin
						state_q <= ST_END;
					end
				end
				ST_RDC: state_q <= ST_ACC;
				ST_ACC: begin
					off_q <= class_rd_q;
					if (accept_rd_q != '0) begin
						la_state_q <= dfa_q;
						la_off_q <= scan_pos_q;
					end
					w_q <= dfa_q;
					steps_q <= '0;
					state_q <= ST_W1;
				end
				ST_W1: begin
					slot_q <= slot_c;
					state_q <= ST_W2;
				end
				ST_W2: begin
					if (hit) begin
						state_q <= ST_NX;
					end else begin
						w_q <= w_new;
						steps_q <= steps_q + TW'(1);
						state_q <= meta_hit ? ST_META : ST_W1;
					end
				end
				ST_META: state_q <= ST_MW;
				ST_MW: begin
					off_q <= meta_rd_q;
					state_q <= ST_W1;
				end
				ST_NX: begin
					dfa_q <= d_new;
					scan_pos_q <= scan_pos_q + PW'(1);
					state_q <= ST_JAM;
				end
				ST_JAM: begin
					state_q <= (base_rd_q == cfg.jam_base || sent_q) ? ST_F1 : ST_SCAN;
				end
				ST_F1: begin
					if (accept_rd_q != '0) begin
						act_q <= accept_rd_q;
						len_q <= f1_len;
						state_q <= ST_F3;
					end else begin
						len_q <= la_off_q;
						state_q <= ST_F2;
					end
				end
				ST_F2: begin
					act_q <= accept_rd_q;
					state_q <= ST_F3;
				end
				ST_F3: begin
					if (pend_ok) begin
						if (pend_v_q) begin
							out_q <= pend_q;
							out_v_q <= 1'b1;
						end
						pend_q <= '{action: noacc ? 10'd0 : act_q, token_start: text_off_q,
							token_length: noacc ? 9'd1 : 9'(len_q),
							status: noacc ? cdfa_pkg::STAT_NOACC : cdfa_pkg::STAT_OK,
							last: 1'b0};
						pend_v_q <= 1'b1;
						res_cnt_q <= res_cnt_q + RW'(1);
						text_off_q <= text_off_q + 32'(cons);
						head_q <= wrap({1'b0, PW'(head_q)} + {1'b0, cons});
						buf_cnt_q <= buf_cnt_q - cons;
						scan_pos_q <= '0;
						state_q <= ST_F4;
					end
				end
				ST_F4: begin
					lsf_q <= buf_rd_q == cdfa_pkg::CHAR_NL;
					state_q <= ST_SCAN;
				end
				ST_END: begin
					if (pend_ok) begin
						if (pend_v_q) begin
							out_q <= pend_q;
							out_q.last <= 1'b1;
							out_v_q <= 1'b1;
							pend_v_q <= 1'b0;
						end
						if (at_end_q && buf_cnt_q == '0) begin
							text_off_q <= '0;
							lsf_q <= 1'b1;
							scan_pos_q <= '0;
							dfa_q <= start_state(cfg.start_condition, 1'b1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(buf_cnt_q) <= 32'(LOOKAHEAD))
		else $error("lookahead count beyond depth");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(res_cnt_q) <= 32'(cdfa_pkg::MAX_RES))
		else $error("result count beyond limit");

	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("pending result left at item end");

	a_backup_order: assert property (@(posedge clk) disable iff (!arst_n)
		la_off_q <= scan_pos_q || scan_pos_q == '0)
		else $error("backup offset past scan position");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(scan_pos_q) <= 32'(buf_cnt_q) + 32'(1))
		else $error("scan position past buffer");

endmodule

// File: rtl/compressed_dfa_longest_match_scanner_core.sv
// Longest-match lexer core over compressed DFA tables (class, meta, accept, base, default,
// check, next). Load items write one table entry each; character items are buffered in a
// LOOKAHEAD-deep lookahead memory and scanned; an end-of-text item flushes the buffer with a
// NUL sentinel. Each result carries the action number, token start offset, length, status
// and a last flag on the final result of its item. An item is first queued in a four-entry
// queue, then run by a sequencer over single-port table memories: a load writes one entry; a
// character step walks the default chain with meta remaps and each token adds finish states;
// result delivery waits on out_ready. Tables power up undefined and must be loaded before
// use; registers must be written only while idle, which the block itself does not enforce.
module compressed_dfa_longest_match_scanner_core #(
	parameter int STATES = 1024,
	parameter int SLOTS = 4096,
	parameter int LOOKAHEAD = 256
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic [2:0] table_id,
	input logic [11:0] table_index,
	input logic [11:0] table_value,
	input logic [7:0] text_char,
	output logic out_valid,
	input logic out_ready,
	output logic [9:0] action,
	output logic [31:0] token_start,
	output logic [8:0] token_length,
	output logic [1:0] status,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [11:0] cfg_data
);

	cdfa_pkg::cfg_t cfg_q;
	cdfa_pkg::item_t q_item;
	cdfa_pkg::res_t res;
	logic q_valid, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_condition <= 5'd0;
			cfg_q.meta_threshold <= 11'd1024;
			cfg_q.jam_base <= 12'd4095;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cdfa_pkg::CFG_START_COND: cfg_q.start_condition <= cfg_data[4:0];
				cdfa_pkg::CFG_META_THR: cfg_q.meta_threshold <= cfg_data[10:0];
				cdfa_pkg::CFG_JAM_BASE: cfg_q.jam_base <= cfg_data;
				default: ;
			endcase
		end
	end

	cdfa_front #(
		.STATES(STATES),
		.SLOTS(SLOTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.table_id(table_id),
		.table_index(table_index),
		.table_value(table_value),
		.text_char(text_char),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	cdfa_back #(
		.STATES(STATES),
		.SLOTS(SLOTS),
		.LOOKAHEAD(LOOKAHEAD)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res)
	);

	assign action = res.action;
	assign token_start = res.token_start;
	assign token_length = res.token_length;
	assign status = res.status;
	assign last = res.last;

endmodule
